@@ hdl/dlh13_pkg.sv @@
// shared types and constants for the dlh13 term score core
`default_nettype none
package dlh13_pkg;

    // configuration register indexes
    localparam logic CFG_MEAN_LEN  = 1'b0;
    localparam logic CFG_DOC_COUNT = 1'b1;

    // log2(pi) with 30 fraction bits
    localparam logic [31:0] LOG2PI_Q30 = 32'd1773280466;

    // widest argument of any logarithm
    localparam int LOG_ARG_W = 40;
    // bits of the integer part of a logarithm
    localparam int LOG_INT_W = 6;

    typedef struct packed {
        logic [31:0] doc_tag;
        logic [23:0] doc_length;
        logic [15:0] term_freq;
        logic [39:0] coll_freq;
    } in_word_t;

    typedef struct packed {
        logic [31:0]        doc_tag_out;
        logic signed [31:0] score;
        logic               invalid;
    } out_word_t;

    // control traveling alongside the logarithm pipes
    typedef struct packed {
        logic        valid;
        logic        invalid;
        logic [31:0] tag;
        logic [15:0] tf;
    } log_side_t;

    // control traveling alongside the divider
    typedef struct packed {
        logic        valid;
        logic        invalid;
        logic        neg;
        logic [31:0] tag;
    } div_side_t;

endpackage
`default_nettype wire

@@ hdl/dlh13_log2_pipe.sv @@
// pipelined fixed-point log2 of an integer, one squaring per stage
`default_nettype none
module dlh13_log2_pipe #(
    parameter int LOG_FRAC_BITS = 20
) (
    input  wire logic                                                aclk,
    input  wire logic                                                en,
    input  wire logic [dlh13_pkg::LOG_ARG_W-1:0]                     x,
    output logic [dlh13_pkg::LOG_INT_W+LOG_FRAC_BITS-1:0]            log_out
);
    localparam int AW = dlh13_pkg::LOG_ARG_W;
    localparam int EW = dlh13_pkg::LOG_INT_W;

    logic [31:0]              m_reg    [0:LOG_FRAC_BITS];
    logic [EW-1:0]            e_reg    [0:LOG_FRAC_BITS];
    logic [LOG_FRAC_BITS-1:0] frac_reg [0:LOG_FRAC_BITS];

    // leading one search and mantissa alignment
    logic [EW-1:0]   e_next;
    logic [AW+30:0]  aligned;
    always_comb begin
        e_next = '0;
        for (int i = 0; i < AW; i++) begin
            if (x[i]) begin
                e_next = EW'(i);
            end
        end
        aligned = {x, 31'b0} >> e_next;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg[0]    <= aligned[31:0];
            e_reg[0]    <= e_next;
            frac_reg[0] <= '0;
        end
    end

    // one fraction bit per stage: square, renormalize
    for (genvar k = 1; k <= LOG_FRAC_BITS; k++) begin : g_sq
        logic [63:0] sq;
        logic [32:0] sq_sh;
        assign sq    = 64'(m_reg[k-1]) * 64'(m_reg[k-1]);
        assign sq_sh = sq[63:31];
        always_ff @(posedge aclk) begin
            if (en) begin
                m_reg[k]    <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
                e_reg[k]    <= e_reg[k-1];
                frac_reg[k] <= {frac_reg[k-1][LOG_FRAC_BITS-2:0], sq_sh[32]};
            end
        end
    end

    assign log_out = {e_reg[LOG_FRAC_BITS], frac_reg[LOG_FRAC_BITS]};
endmodule
`default_nettype wire

@@ hdl/dlh13_div_pipe.sv @@
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module dlh13_div_pipe #(
    parameter int XW = 49,
    parameter int YW = 22
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire dlh13_pkg::div_side_t  side_in,
    input  wire logic [XW-1:0]         x,
    input  wire logic [YW-1:0]         y,
    output dlh13_pkg::div_side_t       side_out,
    output logic [XW-1:0]              q
);
    dlh13_pkg::div_side_t side_reg [0:XW];
    logic [YW-1:0] rem_reg [0:XW];
    logic [XW-1:0] x_reg   [0:XW];
    logic [YW-1:0] y_reg   [0:XW];
    logic [XW-1:0] q_reg   [0:XW];

    // entry stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg[0].valid <= 1'b0;
        end else if (en) begin
            side_reg[0].valid <= side_in.valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0].invalid <= side_in.invalid;
            side_reg[0].neg     <= side_in.neg;
            side_reg[0].tag     <= side_in.tag;
            rem_reg[0]          <= '0;
            x_reg[0]            <= x;
            y_reg[0]            <= y;
            q_reg[0]            <= '0;
        end
    end

    // shift in one dividend bit, subtract when it fits
    for (genvar k = 1; k <= XW; k++) begin : g_st
        logic [YW:0] trial;
        logic        fits;
        assign trial = {rem_reg[k-1], x_reg[k-1][XW-1]};
        assign fits  = trial >= {1'b0, y_reg[k-1]};
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg[k].valid <= 1'b0;
            end else if (en) begin
                side_reg[k].valid <= side_reg[k-1].valid;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k].invalid <= side_reg[k-1].invalid;
                side_reg[k].neg     <= side_reg[k-1].neg;
                side_reg[k].tag     <= side_reg[k-1].tag;
                rem_reg[k] <= fits ? YW'(trial - {1'b0, y_reg[k-1]}) : YW'(trial);
                x_reg[k]   <= {x_reg[k-1][XW-2:0], 1'b0};
                y_reg[k]   <= y_reg[k-1];
                q_reg[k]   <= {q_reg[k-1][XW-2:0], fits};
            end
        end
    end

    assign side_out = side_reg[XW];
    assign q        = q_reg[XW];
endmodule
`default_nettype wire

@@ hdl/dlh13_term_score_core.sv @@
// top level of the dlh13 term score core
// Computes the DLH13 divergence-from-randomness score for one posting word.
// Input words arrive on s_valid/s_ready/s_word; one result word per input
// leaves on m_valid/m_ready/m_word with the document tag, the signed score
// (SCORE_FRAC_BITS fraction bits, saturated, offset of ten included) and an
// invalid flag. The user is to write mean document length and document count
// on the cfg_we/cfg_index/cfg_data port only while no word is in flight; the
// core does not enforce this. Throughput is one word per cycle unless the
// output stalls. A word passes the input register, six logarithm pipes
// (alignment stage plus one per fraction bit), log-term, numerator and divider
// setup registers, the divider (entry stage plus one per quotient bit, XW =
// LOG_FRAC_BITS + 29 + max(0, SCORE_FRAC_BITS - LOG_FRAC_BITS)) and the result
// register. When the receiver holds m_ready low with a result waiting, every
// stage freezes together and s_ready drops; nothing is lost or repeated.
// Reset clears all valid bits and restores mean length 1.0 and count 1.
`default_nettype none
module dlh13_term_score_core #(
    parameter int SCORE_FRAC_BITS = 16,
    parameter int LOG_FRAC_BITS   = 20
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire dlh13_pkg::in_word_t  s_word,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output dlh13_pkg::out_word_t      m_word,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [39:0]          cfg_data
);
    localparam int LF     = LOG_FRAC_BITS;
    localparam int LW     = dlh13_pkg::LOG_INT_W + LF;
    localparam int AW     = LF + 9;
    localparam int NUMW   = AW + 19;
    localparam int SH_UP  = (SCORE_FRAC_BITS > LF) ? SCORE_FRAC_BITS - LF : 0;
    localparam int SH_DN  = (LF > SCORE_FRAC_BITS) ? LF - SCORE_FRAC_BITS : 0;
    localparam int DW     = 17 + SH_DN;
    localparam int YW     = DW + 1;
    localparam int XW     = NUMW + SH_UP + 1;
    localparam int SW     = XW + 2;
    localparam logic [31:0] LOG2PI_SH = dlh13_pkg::LOG2PI_Q30 >> (30 - LOG_FRAC_BITS);
    localparam logic signed [AW-1:0] A_CONST = AW'(64'd8 << LOG_FRAC_BITS);
    localparam logic signed [AW-1:0] B_CONST =
        AW'((64'd1 << LOG_FRAC_BITS) + 64'(LOG2PI_SH));
    localparam logic signed [SW-1:0] OFFSET  = SW'(64'd10 << SCORE_FRAC_BITS);
    localparam logic signed [SW-1:0] SAT_HI  = SW'(64'h7FFF_FFFF);
    localparam logic signed [SW-1:0] SAT_LO  = -SW'(64'h8000_0000);

    logic en;

    // configuration registers
    logic [31:0] mean_len_reg;
    logic [39:0] doc_count_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_len_reg  <= 32'd256;
            doc_count_reg <= 40'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                dlh13_pkg::CFG_MEAN_LEN:  mean_len_reg  <= cfg_data[31:0];
                dlh13_pkg::CFG_DOC_COUNT: doc_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipeline moves unless a finished word is held
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // input register
    logic                  in_valid_reg;
    dlh13_pkg::in_word_t   in_word_reg;
    logic                  in_bad_reg;
    logic                  bad_next;
    assign bad_next = (s_word.doc_length == '0) || (s_word.coll_freq == '0) ||
                      (s_word.term_freq == '0) || (mean_len_reg == '0) ||
                      (doc_count_reg == '0) ||
                      (24'(s_word.term_freq) >= s_word.doc_length);
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            in_word_reg <= s_word;
            in_bad_reg  <= bad_next;
        end
    end

    // six logarithm pipes
    logic [LW-1:0] l_tf, l_avg, l_n, l_len, l_cf, l_rest;
    logic [23:0]   rest_len;
    assign rest_len = in_word_reg.doc_length - 24'(in_word_reg.term_freq);

    dlh13_log2_pipe #(.LOG_FRAC_BITS(LF)) u_log_tf (
        .aclk(aclk), .en(en), .x(40'(in_word_reg.term_freq)), .log_out(l_tf));
    dlh13_log2_pipe #(.LOG_FRAC_BITS(LF)) u_log_avg (
        .aclk(aclk), .en(en), .x(40'(mean_len_reg)), .log_out(l_avg));
    dlh13_log2_pipe #(.LOG_FRAC_BITS(LF)) u_log_n (
        .aclk(aclk), .en(en), .x(doc_count_reg), .log_out(l_n));
    dlh13_log2_pipe #(.LOG_FRAC_BITS(LF)) u_log_len (
        .aclk(aclk), .en(en), .x(40'(in_word_reg.doc_length)), .log_out(l_len));
    dlh13_log2_pipe #(.LOG_FRAC_BITS(LF)) u_log_cf (
        .aclk(aclk), .en(en), .x(in_word_reg.coll_freq), .log_out(l_cf));
    dlh13_log2_pipe #(.LOG_FRAC_BITS(LF)) u_log_rest (
        .aclk(aclk), .en(en), .x(40'(rest_len)), .log_out(l_rest));

    // control delay line beside the logarithm pipes
    dlh13_pkg::log_side_t side_reg [0:LF];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= LF; i++) begin
                side_reg[i].valid <= 1'b0;
            end
        end else if (en) begin
            side_reg[0].valid   <= in_valid_reg;
            side_reg[0].invalid <= in_bad_reg;
            side_reg[0].tag     <= in_word_reg.doc_tag;
            side_reg[0].tf      <= in_word_reg.term_freq;
            for (int i = 1; i <= LF; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // combine the logarithms into the two log terms
    logic signed [AW-1:0] z_tf, z_avg, z_n, z_len, z_cf, z_rest;
    assign z_tf   = AW'(l_tf);
    assign z_avg  = AW'(l_avg);
    assign z_n    = AW'(l_n);
    assign z_len  = AW'(l_len);
    assign z_cf   = AW'(l_cf);
    assign z_rest = AW'(l_rest);

    dlh13_pkg::log_side_t ab_side_reg;
    logic signed [AW-1:0] a_reg, b_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ab_side_reg.valid <= 1'b0;
        end else if (en) begin
            ab_side_reg.valid <= side_reg[LF].valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            ab_side_reg.invalid <= side_reg[LF].invalid;
            ab_side_reg.tag     <= side_reg[LF].tag;
            ab_side_reg.tf      <= side_reg[LF].tf;
            a_reg <= z_tf + z_avg - A_CONST + z_n - z_len - z_cf;
            b_reg <= B_CONST + z_tf + z_rest - z_len;
        end
    end

    // numerator 2*tf*A + B
    dlh13_pkg::log_side_t num_side_reg;
    logic signed [NUMW-1:0] num_reg;
    logic signed [NUMW-1:0] tf2_s;
    assign tf2_s = NUMW'({ab_side_reg.tf, 1'b0});
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_side_reg.valid <= 1'b0;
        end else if (en) begin
            num_side_reg.valid <= ab_side_reg.valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            num_side_reg.invalid <= ab_side_reg.invalid;
            num_side_reg.tag     <= ab_side_reg.tag;
            num_side_reg.tf      <= ab_side_reg.tf;
            num_reg <= tf2_s * NUMW'(a_reg) + NUMW'(b_reg);
        end
    end

    // magnitude and rounding setup for the divider
    dlh13_pkg::div_side_t dv_side_reg;
    logic [XW-1:0] dv_x_reg;
    logic [YW-1:0] dv_y_reg;
    logic          num_neg;
    logic [NUMW-1:0] num_mag;
    logic [DW-1:0]   den;
    assign num_neg = num_reg[NUMW-1];
    assign num_mag = num_neg ? NUMW'(-num_reg) : NUMW'(num_reg);
    assign den     = DW'({num_side_reg.tf, 1'b1}) << SH_DN;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_side_reg.valid <= 1'b0;
        end else if (en) begin
            dv_side_reg.valid <= num_side_reg.valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            dv_side_reg.invalid <= num_side_reg.invalid;
            dv_side_reg.neg     <= num_neg;
            dv_side_reg.tag     <= num_side_reg.tag;
            dv_x_reg <= ((XW'(num_mag) << SH_UP) << 1) + XW'(den);
            dv_y_reg <= YW'(den) << 1;
        end
    end

    dlh13_pkg::div_side_t q_side;
    logic [XW-1:0] q;
    dlh13_div_pipe #(.XW(XW), .YW(YW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .en(en), .side_in(dv_side_reg),
        .x(dv_x_reg), .y(dv_y_reg), .side_out(q_side), .q(q));

    // sign, offset and saturation into the result register
    logic signed [SW-1:0] q_s, s_sum;
    logic signed [31:0]   score_next;
    assign q_s   = q_side.neg ? -$signed(SW'(q)) : $signed(SW'(q));
    assign s_sum = q_s + OFFSET;
    always_comb begin
        if (q_side.invalid) begin
            score_next = '0;
        end else if (s_sum > SAT_HI) begin
            score_next = 32'sh7FFF_FFFF;
        end else if (s_sum < SAT_LO) begin
            score_next = 32'sh8000_0000;
        end else begin
            score_next = s_sum[31:0];
        end
    end

    logic                 m_valid_reg;
    dlh13_pkg::out_word_t m_word_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= q_side.valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            m_word_reg.doc_tag_out <= q_side.tag;
            m_word_reg.score       <= score_next;
            m_word_reg.invalid     <= q_side.invalid;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;
endmodule
`default_nettype wire

@@ hdl/dlh13_term_score_checker.sv @@
// port-level assertions for the dlh13 term score core and their bind
`default_nettype none
module dlh13_term_score_checker (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_ready,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire dlh13_pkg::out_word_t m_word
);
    // a held result word does not change
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    // flagged words carry a zero score
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.invalid |-> m_word.score == 32'sd0)
        else $error("invalid word with nonzero score");

    // input only backs up behind a stalled output
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output stall");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");
endmodule

bind dlh13_term_score_core dlh13_term_score_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_word(m_word));
`default_nettype wire

@@ verif/tb_top.sv @@
// self-checking testbench for the dlh13 term score core
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LOG_FB   = 20;
    localparam int SCORE_FB = 16;
    localparam int LATENCY  = 76;
    localparam longint CYCLE_LIMIT = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    dlh13_pkg::in_word_t s_word = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    dlh13_pkg::out_word_t m_word;
    logic cfg_we = 1'b0;
    logic cfg_index = dlh13_pkg::CFG_MEAN_LEN;
    logic [39:0] cfg_data = '0;

    // predictor copy of the configuration
    logic [31:0] mean_len_q8 = 32'd256;
    logic [39:0] doc_count = 40'd1;

    dlh13_pkg::in_word_t pending_words[$];
    dlh13_pkg::out_word_t expected_scores[$];
    int errors = 0;
    longint cycle_count = 0;
    bit stall_long = 1'b0;
    bit feed_on = 1'b0;

    dlh13_term_score_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_word(s_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_word(m_word),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // fixed point log2 by repeated squaring
    function automatic longint flog2(input logic [63:0] x);
        int e;
        logic [63:0] m;
        longint fr;
        e = 0;
        fr = 0;
        if (x == 0) return 0;
        for (int i = 0; i < 64; i++) if (x[i]) e = i;
        m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
        for (int i = 0; i < LOG_FB; i++) begin
            m = (m * m) >> 31;
            fr = fr << 1;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                fr = fr | 1;
            end
        end
        return (longint'(e) << LOG_FB) + fr;
    endfunction

    // expected result word for one posting
    function automatic dlh13_pkg::out_word_t dlh13_score(input dlh13_pkg::in_word_t w);
        dlh13_pkg::out_word_t r;
        longint a, b, num2, s;
        logic [63:0] tf, len, mag, den, q;
        bit neg;
        tf = w.term_freq;
        len = w.doc_length;
        r.doc_tag_out = w.doc_tag;
        r.score = '0;
        r.invalid = 1'b1;
        if (len == 0 || w.coll_freq == 0 || tf == 0 || mean_len_q8 == 0
            || doc_count == 0 || tf >= len) return r;
        a = flog2(tf) + flog2(mean_len_q8) - (longint'(8) << LOG_FB)
            + flog2(doc_count) - flog2(len) - flog2(w.coll_freq);
        b = (longint'(1) << LOG_FB) + longint'(dlh13_pkg::LOG2PI_Q30 >> (30 - LOG_FB))
            + flog2(tf) + flog2(len - tf) - flog2(len);
        num2 = 2 * longint'(tf) * a + b;
        neg = num2 < 0;
        mag = neg ? -num2 : num2;
        den = (2 * tf + 1) << (LOG_FB - SCORE_FB);
        q = (2 * mag + den) / (2 * den);
        s = neg ? -longint'(q) : longint'(q);
        s += longint'(10) << SCORE_FB;
        if (s > (longint'(1) << 31) - 1) s = (longint'(1) << 31) - 1;
        if (s < -(longint'(1) << 31)) s = -(longint'(1) << 31);
        r.score = s[31:0];
        r.invalid = 1'b0;
        return r;
    endfunction

    // driver: bursts and gaps; prediction at acceptance
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (s_valid && s_ready) expected_scores.push_back(dlh13_score(s_word));
        if (!s_valid || s_ready) begin
            if (s_valid && s_ready) void'(pending_words.pop_front());
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (feed_on && pending_words.size() > 0) begin
                s_word <= pending_words[0];
                s_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 30);
                    if ($urandom_range(0, 2) != 0) gap_left <= $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern and result check
    int stall_phase = 0;
    always @(posedge aclk) begin
        dlh13_pkg::out_word_t exp_w;
        if (m_valid && m_ready) begin
            if (expected_scores.size() == 0) begin
                $error("unexpected word tag=%h", m_word.doc_tag_out);
                errors++;
            end else begin
                exp_w = expected_scores.pop_front();
                if (m_word.doc_tag_out !== exp_w.doc_tag_out) begin
                    $error("doc_tag_out exp %h got %h", exp_w.doc_tag_out, m_word.doc_tag_out);
                    errors++;
                end
                if (m_word.score !== exp_w.score) begin
                    $error("score exp %0d got %0d", exp_w.score, m_word.score);
                    errors++;
                end
                if (m_word.invalid !== exp_w.invalid) begin
                    $error("invalid exp %b got %b", exp_w.invalid, m_word.invalid);
                    errors++;
                end
            end
        end
        stall_phase <= (stall_phase + 1) % 64;
        if (stall_long) m_ready <= 1'b0;
        else if (stall_phase < 24) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    // long hold-off so the pipeline fills and s_ready drops
    initial begin
        wait (pending_words.size() > 100);
        stall_long = 1'b1;
        repeat (400) @(posedge aclk);
        stall_long = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input logic [39:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == dlh13_pkg::CFG_MEAN_LEN) mean_len_q8 = val[31:0];
        else doc_count = val;
    endtask

    task automatic drain_pipe();
        wait (pending_words.size() == 0 && !s_valid);
        wait (expected_scores.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    function automatic dlh13_pkg::in_word_t rand_posting();
        dlh13_pkg::in_word_t w;
        int k;
        w.doc_tag = $urandom;
        k = $urandom_range(0, 9);
        w.doc_length = (k == 0) ? 24'($urandom) : 24'($urandom_range(2, 4000));
        w.term_freq = (k == 1) ? 16'($urandom) : 16'($urandom_range(1, 60));
        if (k == 2) w.term_freq = 16'(w.doc_length);
        w.coll_freq = (k == 3) ? {8'($urandom), 32'($urandom)}
                               : 40'($urandom_range(1, 100000));
        if (k == 4) w.coll_freq = '0;
        return w;
    endfunction

    task automatic run_phase(input int n);
        for (int i = 0; i < n; i++) pending_words.push_back(rand_posting());
        drain_pipe();
    endtask

    initial begin
        dlh13_pkg::in_word_t w;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        write_reg(dlh13_pkg::CFG_MEAN_LEN, 40'd300 << 8);
        write_reg(dlh13_pkg::CFG_DOC_COUNT, 40'd1000000);
        // directed corners
        w = '{32'hFFFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 40'hFF_FFFF_FFFF};
        pending_words.push_back(w);
        pending_words.push_back('{32'h0, 24'd0, 16'd1, 40'd5});
        pending_words.push_back('{32'h1, 24'd10, 16'd0, 40'd5});
        pending_words.push_back('{32'h2, 24'd10, 16'd10, 40'd5});
        pending_words.push_back('{32'h3, 24'd10, 16'd11, 40'd5});
        pending_words.push_back('{32'h4, 24'd10, 16'd3, 40'd0});
        pending_words.push_back('{32'h5, 24'd2, 16'd1, 40'd1});
        pending_words.push_back('{32'h6, 24'hFF_FFFF, 16'd1, 40'hFF_FFFF_FFFF});
        pending_words.push_back('{32'h7, 24'hFF_FFFF, 16'hFFFF, 40'd1});
        pending_words.push_back('{32'h8, 24'd65536, 16'hFFFF, 40'd1});
        feed_on = 1'b1;
        drain_pipe();
        run_phase(150);
        // extremes of the registers
        write_reg(dlh13_pkg::CFG_MEAN_LEN, 40'hFFFF_FFFF);
        write_reg(dlh13_pkg::CFG_DOC_COUNT, 40'hFF_FFFF_FFFF);
        run_phase(60);
        write_reg(dlh13_pkg::CFG_MEAN_LEN, 40'd1);
        write_reg(dlh13_pkg::CFG_DOC_COUNT, 40'd1);
        run_phase(60);
        write_reg(dlh13_pkg::CFG_MEAN_LEN, 40'd0);
        run_phase(20);
        write_reg(dlh13_pkg::CFG_MEAN_LEN, 40'd256);
        write_reg(dlh13_pkg::CFG_DOC_COUNT, 40'd0);
        run_phase(20);
        write_reg(dlh13_pkg::CFG_DOC_COUNT, {8'($urandom), 32'($urandom)});
        write_reg(dlh13_pkg::CFG_MEAN_LEN, 40'($urandom));
        run_phase(100);
        if (errors == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
